// ===== sv/setc_pkg.sv =====
// Shared types and constants for the scope edge trigger capture block.
package setc_pkg;

    localparam int unsigned C_SAMPLE_W   = 16;
    localparam int unsigned C_SLOT_W     = 10;
    localparam int unsigned C_STAMP_W    = 40;
    localparam int unsigned C_RAW_W      = 48;
    localparam int unsigned C_SKIP_W     = 16;
    localparam int unsigned C_HOLD_W     = 31;
    localparam int unsigned C_SHIFT_W    = 4;
    localparam int unsigned C_SRC_W      = 2;
    localparam int unsigned C_MODE_W     = 2;
    localparam int unsigned C_CFG_IDX_W  = 3;
    localparam int unsigned C_CFG_DATA_W = 31;
    localparam int unsigned C_MAX_CHAN   = 4;

    // Sets per capture; slot is C_SLOT_W bits, so at most 1023.
    localparam logic [C_SLOT_W-1:0] C_CAPTURE_DEPTH = 10'd800;

    // Timestamp is raw_count * 2 / 1000, i.e. raw_count / 500.
    localparam int unsigned C_STAMP_DIV = 1000 / 2;
    localparam int unsigned C_REM_W     = $clog2(C_STAMP_DIV);
    localparam logic [C_REM_W-1:0] C_REM_LAST = C_REM_W'(C_STAMP_DIV - 1);

    localparam logic [C_HOLD_W-1:0] C_HOLDOFF_RESET = 31'd1000;

    // Configuration register indexes.
    localparam logic [C_CFG_IDX_W-1:0] CFG_DECIM_SHIFT = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_TRIG_SOURCE = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] CFG_TRIG_THRESH = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] CFG_HOLDOFF     = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] CFG_ARM_MODE    = 3'd4;
    localparam logic [C_CFG_IDX_W-1:0] CFG_EDGE_DIR    = 3'd5;

    // Arm modes.
    localparam logic [C_MODE_W-1:0] MODE_STOPPED    = 2'd0;
    localparam logic [C_MODE_W-1:0] MODE_SINGLE     = 2'd1;
    localparam logic [C_MODE_W-1:0] MODE_CONTINUOUS = 2'd2;
    localparam logic [C_MODE_W-1:0] MODE_ALIAS      = 2'd3;

    // Edge directions.
    localparam logic EDGE_RISING  = 1'b0;
    localparam logic EDGE_FALLING = 1'b1;

    typedef struct packed {
        logic signed [C_SAMPLE_W-1:0] chan0;
        logic signed [C_SAMPLE_W-1:0] chan1;
        logic signed [C_SAMPLE_W-1:0] chan2;
        logic signed [C_SAMPLE_W-1:0] chan3;
    } t_in_set;

    typedef struct packed {
        logic signed [C_SAMPLE_W-1:0] cap0;
        logic signed [C_SAMPLE_W-1:0] cap1;
        logic signed [C_SAMPLE_W-1:0] cap2;
        logic signed [C_SAMPLE_W-1:0] cap3;
        logic [C_SLOT_W-1:0]          slot;
        logic                         final_res;
        logic [C_STAMP_W-1:0]         stamp_ms;
        logic [C_MODE_W-1:0]          mode_after;
    } t_out_set;

endpackage

// ===== sv/setc_outq.sv =====
// Two-entry result queue that decouples the sample path from output stalls.
module setc_outq
    import setc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_out_set i_data,
    output logic     o_full,
    output logic     o_valid,
    output t_out_set o_data,
    input  logic     i_stall
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_out_set   r_head;
    t_out_set   n_head;
    t_out_set   r_tail;
    t_out_set   n_tail;
    logic       pop;
    logic       push;

    assign pop  = (r_cnt != 2'd0) && !i_stall;
    assign push = i_push && (r_cnt != 2'd2);

    always_comb begin
        n_cnt  = r_cnt;
        n_head = r_head;
        n_tail = r_tail;
        case (r_cnt)
            2'd0: begin
                if (push) begin
                    n_head = i_data;
                    n_cnt  = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    n_head = i_data;
                end else if (push) begin
                    n_tail = i_data;
                    n_cnt  = 2'd2;
                end else if (pop) begin
                    n_cnt  = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    n_head = r_tail;
                    n_cnt  = 2'd1;
                end
            end
            default: begin
                n_cnt = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Payload holds no reset.
    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_head;

endmodule

// ===== sv/scope_edge_trigger_capture_top.sv =====
// Top level of the scope edge trigger capture block.
//
//  Channel   Direction  Handshake                Payload
//  in        sink       i_in_valid / o_in_stall   i_in_data  (t_in_set)
//  out       source     o_out_valid / i_out_stall o_out_data (t_out_set)
//  cfg       sink       i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One sample set is taken every cycle unless the input is stalled; all trigger,
// decimation and holdoff logic for a set runs in the transfer cycle and any
// result it produces is registered in a two-entry output queue.
// The input stalls only while that queue holds two results the consumer has
// not taken. Reset is synchronous; there is no clearing pass. The timestamp
// divide is replaced by a running quotient/remainder pair.
module scope_edge_trigger_capture_top
    import setc_pkg::*;
#(
    parameter int unsigned NUM_CHANNELS = 4
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // sample input
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_set                 i_in_data,
    // result output
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_set                o_out_data,
    // configuration writes
    input  logic                    i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [C_CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic        [C_SHIFT_W-1:0]  r_shift;
    logic        [C_SRC_W-1:0]    r_src;
    logic signed [C_SAMPLE_W-1:0] r_thresh;
    logic        [C_HOLD_W-1:0]   r_holdoff;
    logic        [C_MODE_W-1:0]   r_arm_mode;
    logic                         r_edge_dir;

    // Running state.
    logic signed [C_SAMPLE_W-1:0] r_prev [NUM_CHANNELS];
    logic        [C_SKIP_W-1:0]   r_skip;
    logic        [C_SKIP_W-1:0]   n_skip;
    logic        [C_HOLD_W-1:0]   r_hold_left;
    logic        [C_HOLD_W-1:0]   n_hold_left;
    logic                         r_capturing;
    logic                         n_capturing;
    logic        [C_SLOT_W-1:0]   r_fill;
    logic        [C_SLOT_W-1:0]   n_fill;
    logic        [C_RAW_W-1:0]    r_raw;
    logic        [C_RAW_W-1:0]    n_raw;
    logic        [C_STAMP_W-1:0]  r_quot;
    logic        [C_STAMP_W-1:0]  n_quot;
    logic        [C_REM_W-1:0]    r_rem;
    logic        [C_REM_W-1:0]    n_rem;
    logic                         r_disarmed;
    logic                         n_disarmed;

    // Per-set combinational values.
    logic signed [C_SAMPLE_W-1:0] cur  [C_MAX_CHAN];
    logic signed [C_SAMPLE_W-1:0] prev [C_MAX_CHAN];
    logic signed [C_SAMPLE_W-1:0] trig_before;
    logic signed [C_SAMPLE_W-1:0] trig_now;
    logic        [C_SKIP_W-1:0]   skip_inc;
    logic        [C_SKIP_W-1:0]   keep_lim;
    logic        [C_HOLD_W-1:0]   hold_dec;
    logic        [C_MODE_W-1:0]   eff_mode;
    logic        [C_SLOT_W-1:0]   fill_eff;
    logic        [C_SLOT_W-1:0]   fill_inc;
    logic                         keep;
    logic                         hit;
    logic                         trig;
    logic                         emit;
    logic                         last;
    logic                         in_xfer;
    logic                         q_full;
    t_out_set                     res;

    assign in_xfer    = i_in_valid && !q_full;
    assign o_in_stall = q_full;

    // Widen the incoming set to four lanes; absent channels read as zero.
    assign cur[0] = i_in_data.chan0;
    assign cur[1] = (NUM_CHANNELS > 1) ? i_in_data.chan1 : '0;
    assign cur[2] = (NUM_CHANNELS > 2) ? i_in_data.chan2 : '0;
    assign cur[3] = (NUM_CHANNELS > 3) ? i_in_data.chan3 : '0;

    for (genvar g = 0; g < C_MAX_CHAN; g++) begin : g_prev
        if (g < NUM_CHANNELS) begin : g_live
            assign prev[g] = r_prev[g];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_prev[g] <= '0;
                end else if (in_xfer) begin
                    r_prev[g] <= cur[g];
                end
            end
        end else begin : g_absent
            assign prev[g] = '0;
        end
    end

    assign trig_before = prev[r_src];
    assign trig_now    = cur[r_src];

    // Decimation: keep a set once the counter reaches 2^shift.
    assign skip_inc = r_skip + C_SKIP_W'(1);
    assign keep_lim = C_SKIP_W'(1) << r_shift;
    assign keep     = (skip_inc >= keep_lim);

    // Holdoff counts raw sets, decremented before the trigger check.
    assign hold_dec = (r_hold_left != '0) ? (r_hold_left - C_HOLD_W'(1)) : '0;

    // Mode three behaves as continuous.
    always_comb begin
        if (r_disarmed) begin
            eff_mode = MODE_STOPPED;
        end else if (r_arm_mode == MODE_ALIAS) begin
            eff_mode = MODE_CONTINUOUS;
        end else begin
            eff_mode = r_arm_mode;
        end
    end

    always_comb begin
        if (r_edge_dir == EDGE_RISING) begin
            hit = (trig_before < r_thresh) && (trig_now >= r_thresh);
        end else begin
            hit = (trig_before > r_thresh) && (trig_now <= r_thresh);
        end
    end

    assign trig     = keep && (hold_dec == '0) && !r_capturing
                      && (eff_mode != MODE_STOPPED) && hit;
    assign emit     = keep && (r_capturing || trig);
    assign fill_eff = trig ? '0 : r_fill;
    assign fill_inc = fill_eff + C_SLOT_W'(1);
    assign last     = emit && (fill_inc >= C_CAPTURE_DEPTH);

    // Timestamp tracking: quotient and remainder of raw_count by the divisor,
    // cleared together when the raw counter wraps.
    always_comb begin
        n_raw  = r_raw + C_RAW_W'(1);
        n_quot = r_quot;
        n_rem  = r_rem;
        if (r_raw == '1) begin
            n_quot = '0;
            n_rem  = '0;
        end else if (r_rem == C_REM_LAST) begin
            n_quot = r_quot + C_STAMP_W'(1);
            n_rem  = '0;
        end else begin
            n_rem  = r_rem + C_REM_W'(1);
        end
    end

    // Advance the capture state for one transferred set.
    always_comb begin
        n_skip      = keep ? '0 : skip_inc;
        n_hold_left = last ? r_holdoff : hold_dec;
        n_capturing = emit ? !last : r_capturing;
        n_fill      = emit ? fill_inc : r_fill;
        n_disarmed  = r_disarmed || (last && (eff_mode == MODE_SINGLE));
    end

    always_comb begin
        res.cap0       = cur[0];
        res.cap1       = cur[1];
        res.cap2       = cur[2];
        res.cap3       = cur[3];
        res.slot       = fill_eff;
        res.final_res  = last;
        res.stamp_ms   = last ? n_quot : '0;
        res.mode_after = '0;
        if (last && (eff_mode != MODE_SINGLE)) begin
            res.mode_after = eff_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_src       <= '0;
            r_thresh    <= '0;
            r_holdoff   <= C_HOLDOFF_RESET;
            r_arm_mode  <= MODE_STOPPED;
            r_edge_dir  <= EDGE_RISING;
            r_skip      <= '0;
            r_hold_left <= '0;
            r_capturing <= 1'b0;
            r_fill      <= '0;
            r_raw       <= '0;
            r_quot      <= '0;
            r_rem       <= '0;
            r_disarmed  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_skip      <= n_skip;
                r_hold_left <= n_hold_left;
                r_capturing <= n_capturing;
                r_fill      <= n_fill;
                r_raw       <= n_raw;
                r_quot      <= n_quot;
                r_rem       <= n_rem;
            end
            // Writing the arm mode rearms; otherwise advance with the set.
            if (i_cfg_we && (i_cfg_idx == CFG_ARM_MODE)) begin
                r_disarmed <= 1'b0;
            end else if (in_xfer) begin
                r_disarmed <= n_disarmed;
            end
            // Register writes are expected only while idle.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DECIM_SHIFT: r_shift    <= i_cfg_data[C_SHIFT_W-1:0];
                    CFG_TRIG_SOURCE: r_src      <= i_cfg_data[C_SRC_W-1:0];
                    CFG_TRIG_THRESH: r_thresh   <= i_cfg_data[C_SAMPLE_W-1:0];
                    CFG_HOLDOFF:     r_holdoff  <= i_cfg_data[C_HOLD_W-1:0];
                    CFG_ARM_MODE:    r_arm_mode <= i_cfg_data[C_MODE_W-1:0];
                    CFG_EDGE_DIR:    r_edge_dir <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Hold results until the consumer takes them.
    setc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer && emit),
        .i_data  (res),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule
